/* rtl/pwm_input_duty_measure_unit_defines.svh */
// Assertion helpers for the duty measurement block
`ifndef PWM_INPUT_DUTY_MEASURE_UNIT_DEFINES_SVH
`define PWM_INPUT_DUTY_MEASURE_UNIT_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define PIDM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds through reset
`define PIDM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/pidm_pkg.sv */
package pidm_pkg;

    localparam int CHAN_W   = 2;
    localparam int VALUE_W  = 16;
    localparam int DUTY_W   = 7;
    localparam int STEP_W   = 3;

    localparam logic [VALUE_W-1:0] TOP_RESET = 16'hFFFF;
    localparam logic [DUTY_W-1:0]  DUTY_FULL = 7'd100;

    // x * 100 = (x << 6) + (x << 5) + (x << 2)
    localparam int SCALE_SH_A = 6;
    localparam int SCALE_SH_B = 5;
    localparam int SCALE_SH_C = 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HIGH,
        S_HIGH_WRAP,
        S_CYCLE,
        S_CYCLE_WRAP,
        S_CHECK,
        S_MUL,
        S_MUL_ADD,
        S_DIV,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_ADD_ONE,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic rise;
        logic fall;
        logic duty;
    } chan_wr_t;

endpackage

/* rtl/pidm_alu.sv */
module pidm_alu
    import pidm_pkg::*;
#(
    parameter int W = 23
)
(
    input  alu_op_t        op,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [W-1:0]   sum,
    output logic           carry
);

    logic [W-1:0] b_eff;
    logic         cin;
    logic [W:0]   full;

    always_comb
    begin
        b_eff = (op == ALU_SUB) ? ~b : b;
        cin   = (op != ALU_ADD);
        full  = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, cin};
        sum   = full[W-1:0];
        // on subtract, carry set means a >= b
        carry = full[W];
    end

endmodule

/* rtl/pidm_chan_store.sv */
module pidm_chan_store
    import pidm_pkg::*;
#(
    parameter int NUM_CHANNELS = 3,
    parameter int COUNT_BITS   = 16,
    parameter int IDX_W        = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  chan_wr_t              wr,
    input  logic [IDX_W-1:0]      idx,
    input  logic [COUNT_BITS-1:0] stamp,
    input  logic [IDX_W-1:0]      duty_idx,
    input  logic [DUTY_W-1:0]     duty,
    output logic                  awaiting,
    output logic [COUNT_BITS-1:0] rise,
    output logic [COUNT_BITS-1:0] prev,
    output logic [DUTY_W-1:0]     held
);

    logic                  awaiting_reg [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] rise_reg     [NUM_CHANNELS];
    logic [COUNT_BITS-1:0] prev_reg     [NUM_CHANNELS];
    logic [DUTY_W-1:0]     held_reg     [NUM_CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                awaiting_reg[i] <= 1'b0;
                rise_reg[i]     <= '0;
                prev_reg[i]     <= '0;
                held_reg[i]     <= '0;
            end
        end
        else
        begin
            if (wr.rise)
            begin
                awaiting_reg[idx] <= 1'b1;
                rise_reg[idx]     <= stamp;
            end
            if (wr.fall)
            begin
                awaiting_reg[idx] <= 1'b0;
                prev_reg[idx]     <= rise_reg[idx];
            end
            if (wr.duty)
            begin
                held_reg[duty_idx] <= duty;
            end
        end
    end

    assign awaiting = awaiting_reg[idx];
    assign rise     = rise_reg[idx];
    assign prev     = prev_reg[idx];
    assign held     = held_reg[idx];

endmodule

/* rtl/pwm_input_duty_measure_unit.sv */
// PWM input duty measurement.
// Capture channel (cap_valid/cap_stall): one timer capture event per transfer,
// channel and cap_value. Channels alternate rise, fall, rise, ...
// A rising edge only stores its stamp: it is taken while idle and the next
// event may follow in the next cycle. A falling edge starts a measurement on
// one shared adder: wrap-corrected high and cycle time, a saturation check,
// x100 by two shift-adds and a 7-step restoring divide; a zero cycle time or
// a saturated result skips the multiply and divide. cap_stall stays high from
// a falling-edge transfer until the sequencer is back in idle.
// Result channel (res_valid/res_stall): one transfer per falling edge, shown
// from the cycle after the sequencer finishes and held while res_stall is
// high. The output register lets a new event be taken while a result waits;
// only the finishing step of the next measurement waits for the register.
// Events for a channel at or above NUM_CHANNELS are taken and dropped.
// cfg_write_en/cfg_write_data set counter_top; write only while idle.
// Reset clears all channel state to waiting for a rising edge, held duty
// zero, counter_top 65535, and no result pending.
module pwm_input_duty_measure_unit
    import pidm_pkg::*;
#(
    parameter int NUM_CHANNELS = 3,
    parameter int COUNT_BITS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [VALUE_W-1:0] cfg_write_data,
    input  logic               cap_valid,
    output logic               cap_stall,
    input  logic [CHAN_W-1:0]  channel,
    input  logic [VALUE_W-1:0] cap_value,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [CHAN_W-1:0]  result_channel,
    output logic [VALUE_W-1:0] high_time,
    output logic [VALUE_W-1:0] cycle_time,
    output logic [DUTY_W-1:0]  duty_percent
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int W     = COUNT_BITS + DUTY_W;

    state_t state_reg, state_next;

    logic [VALUE_W-1:0]    top_reg;
    logic [IDX_W-1:0]      idx_reg,   idx_next;
    logic [CHAN_W-1:0]     chan_reg,  chan_next;
    logic [COUNT_BITS-1:0] cap_reg,   cap_next;
    logic [COUNT_BITS-1:0] rise_reg,  rise_next;
    logic [COUNT_BITS-1:0] prev_reg,  prev_next;
    logic [COUNT_BITS-1:0] high_reg,  high_next;
    logic [COUNT_BITS-1:0] cycle_reg, cycle_next;
    logic [W-1:0]          acc_reg,   acc_next;
    logic [W-1:0]          div_reg,   div_next;
    logic [DUTY_W-1:0]     quot_reg,  quot_next;
    logic [STEP_W-1:0]     step_reg,  step_next;

    logic                  res_valid_reg, res_valid_next;
    logic [CHAN_W-1:0]     res_chan_reg,  res_chan_next;
    logic [VALUE_W-1:0]    res_high_reg,  res_high_next;
    logic [VALUE_W-1:0]    res_cycle_reg, res_cycle_next;
    logic [DUTY_W-1:0]     res_duty_reg,  res_duty_next;

    logic                  cap_xfer;
    logic                  in_range;
    logic [IDX_W-1:0]      rd_idx;
    logic [COUNT_BITS-1:0] cap_ext;
    logic [COUNT_BITS-1:0] top_ext;

    chan_wr_t              st_wr;
    logic                  st_awaiting;
    logic [COUNT_BITS-1:0] st_rise;
    logic [COUNT_BITS-1:0] st_prev;
    logic [DUTY_W-1:0]     st_held;

    alu_op_t               alu_op;
    logic [W-1:0]          alu_a;
    logic [W-1:0]          alu_b;
    logic [W-1:0]          alu_sum;
    logic                  alu_carry;

    assign cap_stall = (state_reg != S_IDLE);
    assign cap_xfer  = cap_valid && !cap_stall;
    assign in_range  = (32'(channel) < NUM_CHANNELS);
    assign rd_idx    = IDX_W'(channel);
    assign cap_ext   = COUNT_BITS'(cap_value);
    assign top_ext   = COUNT_BITS'(top_reg);

    pidm_chan_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNT_BITS   (COUNT_BITS),
        .IDX_W        (IDX_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (st_wr),
        .idx      (rd_idx),
        .stamp    (cap_ext),
        .duty_idx (idx_reg),
        .duty     (quot_reg),
        .awaiting (st_awaiting),
        .rise     (st_rise),
        .prev     (st_prev),
        .held     (st_held)
    );

    pidm_alu #(
        .W (W)
    ) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= TOP_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_write_en)
            begin
                top_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        chan_reg      <= chan_next;
        cap_reg       <= cap_next;
        rise_reg      <= rise_next;
        prev_reg      <= prev_next;
        high_reg      <= high_next;
        cycle_reg     <= cycle_next;
        acc_reg       <= acc_next;
        div_reg       <= div_next;
        quot_reg      <= quot_next;
        step_reg      <= step_next;
        res_chan_reg  <= res_chan_next;
        res_high_reg  <= res_high_next;
        res_cycle_reg <= res_cycle_next;
        res_duty_reg  <= res_duty_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        chan_next      = chan_reg;
        cap_next       = cap_reg;
        rise_next      = rise_reg;
        prev_next      = prev_reg;
        high_next      = high_reg;
        cycle_next     = cycle_reg;
        acc_next       = acc_reg;
        div_next       = div_reg;
        quot_next      = quot_reg;
        step_next      = step_reg;
        res_chan_next  = res_chan_reg;
        res_high_next  = res_high_reg;
        res_cycle_next = res_cycle_reg;
        res_duty_next  = res_duty_reg;
        res_valid_next = res_valid_reg && res_stall;
        st_wr          = '0;
        alu_op         = ALU_SUB;
        alu_a          = '0;
        alu_b          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cap_xfer && in_range)
                begin
                    if (!st_awaiting)
                    begin
                        st_wr.rise = 1'b1;
                    end
                    else
                    begin
                        st_wr.fall = 1'b1;
                        idx_next   = rd_idx;
                        chan_next  = channel;
                        cap_next   = cap_ext;
                        rise_next  = st_rise;
                        prev_next  = st_prev;
                        // kept as the duty when the cycle time is zero
                        quot_next  = st_held;
                        state_next = S_HIGH;
                    end
                end
            end

            S_HIGH:
            begin
                alu_op     = ALU_SUB;
                alu_a      = W'(cap_reg);
                alu_b      = W'(rise_reg);
                high_next  = alu_sum[COUNT_BITS-1:0];
                state_next = alu_carry ? S_CYCLE : S_HIGH_WRAP;
            end

            S_HIGH_WRAP:
            begin
                alu_op     = ALU_ADD_ONE;
                alu_a      = W'(high_reg);
                alu_b      = W'(top_ext);
                high_next  = alu_sum[COUNT_BITS-1:0];
                state_next = S_CYCLE;
            end

            S_CYCLE:
            begin
                alu_op     = ALU_SUB;
                alu_a      = W'(rise_reg);
                alu_b      = W'(prev_reg);
                cycle_next = alu_sum[COUNT_BITS-1:0];
                state_next = alu_carry ? S_CHECK : S_CYCLE_WRAP;
            end

            S_CYCLE_WRAP:
            begin
                alu_op     = ALU_ADD_ONE;
                alu_a      = W'(cycle_reg);
                alu_b      = W'(top_ext);
                cycle_next = alu_sum[COUNT_BITS-1:0];
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                alu_op = ALU_SUB;
                alu_a  = W'(high_reg);
                alu_b  = W'(cycle_reg);
                if (cycle_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else if (alu_carry)
                begin
                    // high time not below cycle time: full scale
                    quot_next  = DUTY_FULL;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                alu_op     = ALU_ADD;
                alu_a      = W'(high_reg) << SCALE_SH_A;
                alu_b      = W'(high_reg) << SCALE_SH_B;
                acc_next   = alu_sum;
                state_next = S_MUL_ADD;
            end

            S_MUL_ADD:
            begin
                alu_op     = ALU_ADD;
                alu_a      = acc_reg;
                alu_b      = W'(high_reg) << SCALE_SH_C;
                acc_next   = alu_sum;
                // quotient below 2^DUTY_W, so start with the top quotient bit
                div_next   = W'(cycle_reg) << (DUTY_W - 1);
                step_next  = STEP_W'(DUTY_W - 1);
                quot_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                alu_op    = ALU_SUB;
                alu_a     = acc_reg;
                alu_b     = div_reg;
                if (alu_carry)
                begin
                    acc_next = alu_sum;
                end
                quot_next = {quot_reg[DUTY_W-2:0], alu_carry};
                div_next  = div_reg >> 1;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_valid_next = 1'b1;
                    res_chan_next  = chan_reg;
                    res_high_next  = VALUE_W'(high_reg);
                    res_cycle_next = VALUE_W'(cycle_reg);
                    res_duty_next  = quot_reg;
                    st_wr.duty     = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res_valid      = res_valid_reg;
    assign result_channel = res_chan_reg;
    assign high_time      = res_high_reg;
    assign cycle_time     = res_cycle_reg;
    assign duty_percent   = res_duty_reg;

endmodule

/* rtl/pidm_checker.sv */
`include "pwm_input_duty_measure_unit_defines.svh"

module pidm_checker
    import pidm_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               cap_valid,
    input logic               cap_stall,
    input logic [CHAN_W-1:0]  channel,
    input logic [VALUE_W-1:0] cap_value,
    input logic               res_valid,
    input logic               res_stall,
    input logic [CHAN_W-1:0]  result_channel,
    input logic [VALUE_W-1:0] high_time,
    input logic [VALUE_W-1:0] cycle_time,
    input logic [DUTY_W-1:0]  duty_percent
);

    // stalled result must hold
    `PIDM_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(result_channel) && $stable(high_time) && $stable(cycle_time) && $stable(duty_percent), "stalled result changed")

    // stalled capture must hold
    `PIDM_ASSERT(a_cap_hold, cap_valid && cap_stall |=> cap_valid && $stable({channel, cap_value}), "stalled capture changed")

    `PIDM_ASSERT_ALWAYS(a_duty_range, res_valid |-> duty_percent <= DUTY_FULL, "duty above full scale")

    `PIDM_ASSERT(a_chan_range, res_valid |-> 32'(result_channel) < NUM_CHANNELS, "result for unserved channel")

    // a new result only comes out of a busy measurement
    `PIDM_ASSERT(a_res_from_busy, $rose(res_valid) |-> $past(cap_stall), "result without measurement")

endmodule

bind pwm_input_duty_measure_unit pidm_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_pidm_checker (.*);
